// File: hw/rtl/cfa_pkg.sv
// Shared types, character codes and the hex digit function for the CAN frame line encoder.
// No dependencies.
package cfa_pkg;

	localparam logic [6:0] CHAR_CR    = 7'd13;
	localparam logic [6:0] CHAR_EXT_R = 7'h52;	// 'R'
	localparam logic [6:0] CHAR_EXT_T = 7'h54;	// 'T'
	localparam logic [6:0] CHAR_STD_R = 7'h72;	// 'r'
	localparam logic [6:0] CHAR_STD_T = 7'h74;	// 't'
	localparam logic [6:0] CHAR_A     = 7'h41;	// 'A'
	localparam logic [6:0] CHAR_0     = 7'h30;	// '0'
	localparam logic [3:0] MAX_BYTES  = 4'd8;

	typedef struct packed {
		logic [28:0] ident;
		logic        extended;
		logic        remote;
		logic [3:0]  length_code;
		logic [63:0] payload;
		logic [15:0] stamp;
	} in_word_t;

	typedef struct packed {
		logic [6:0] ascii_char;
		logic       last;
	} out_word_t;

	typedef enum logic [2:0] {
		SEL_TYPE,
		SEL_IDENT,
		SEL_DLC,
		SEL_DATA,
		SEL_STAMP,
		SEL_CR
	} sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TYPE,
		ST_IDENT,
		ST_DLC,
		ST_DATA,
		ST_STAMP,
		ST_CR
	} state_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic cnt_clr;
		sel_t sel;
	} cfa_cmd_t;

	typedef struct packed {
		logic out_free;
		logic seg_end;
		logic no_data;
		logic ts_en;
	} cfa_sts_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		if (nib > 4'd9)
			return CHAR_A + {3'd0, nib} - 7'd10;
		return CHAR_0 + {3'd0, nib};
	endfunction

endpackage

// File: hw/rtl/can_frame_to_ascii_line_encoder.sv
// CAN frame to ASCII line encoder: sequencer (cfa_ctrl) plus datapath (cfa_datapath).
// The frame word is registered on acceptance; ST_TYPE then emits the type letter.
// Throughput: one character per cycle while the output is free; a line is 6 to 31
// characters, and the next frame word is taken in ST_IDLE after the carriage return.
// Output backpressure stalls the sequencer one character at a time.
// Reset (arst_n, async low): sequencer idle, output empty, timestamp_enable cleared.
module can_frame_to_ascii_line_encoder
	import cfa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	// command and status between sequencer and datapath
	cfa_cmd_t cmd;
	cfa_sts_t sts;

	// sequencer: type letter, ident digits, length digit, data digits,
	// optional stamp digits, carriage return
	cfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath holds the frame word, the timestamp enable and the output register
	cfa_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: hw/rtl/cfa_ctrl.sv
// Line sequencer: walks the segments of one output line and commands the datapath.
// Depends on cfa_pkg.
module cfa_ctrl
	import cfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cfa_sts_t sts,
	output cfa_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.emit    = 1'b0;
		cmd.cnt_clr = 1'b0;
		cmd.sel     = SEL_TYPE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_TYPE;
				end
			end
			ST_TYPE: begin
				cmd.sel = SEL_TYPE;
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = ST_IDENT;
				end
			end
			ST_IDENT: begin
				cmd.sel = SEL_IDENT;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.seg_end) begin
						cmd.cnt_clr = 1'b1;
						state_d     = ST_DLC;
					end
				end
			end
			ST_DLC: begin
				cmd.sel = SEL_DLC;
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.cnt_clr = 1'b1;
					priority if (!sts.no_data)
						state_d = ST_DATA;
					else if (sts.ts_en)
						state_d = ST_STAMP;
					else
						state_d = ST_CR;
				end
			end
			ST_DATA: begin
				cmd.sel = SEL_DATA;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.seg_end) begin
						cmd.cnt_clr = 1'b1;
						state_d     = sts.ts_en ? ST_STAMP : ST_CR;
					end
				end
			end
			ST_STAMP: begin
				cmd.sel = SEL_STAMP;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.seg_end) begin
						cmd.cnt_clr = 1'b1;
						state_d     = ST_CR;
					end
				end
			end
			ST_CR: begin
				cmd.sel = SEL_CR;
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("character emitted into a full output register");
	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> !sts.no_data)
		else $error("data segment entered for a frame without data bytes");
	a_load_line_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_TYPE))
		else $error("frame load did not start a line");
`endif

endmodule

// File: hw/rtl/cfa_datapath.sv
// Frame register, digit counter, character select and output register.
// Depends on cfa_pkg.
module cfa_datapath
	import cfa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      out_ready,
	output logic      out_valid,
	output out_word_t out_data,
	input  cfa_cmd_t  cmd,
	output cfa_sts_t  sts
);

	in_word_t   frame_q;
	logic [3:0] cnt_q;
	logic       ts_en_q;
	logic       out_valid_q;
	out_word_t  out_q;

	logic [3:0]  nbytes;
	logic [3:0]  data_end;
	logic [31:0] ident32;
	logic [2:0]  id_nib;
	logic [3:0]  pl_nib;
	logic [1:0]  st_nib;
	logic [3:0]  nib;
	logic        seg_end;
	out_word_t   chr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ts_en_q <= 1'b0;
		else if (cfg_we)
			ts_en_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			frame_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 4'd0;
		else if (cmd.load || (cmd.emit && cmd.cnt_clr))
			cnt_q <= 4'd0;
		else if (cmd.emit)
			cnt_q <= cnt_q + 4'd1;
	end

	// data bytes clamp at eight; remote frames carry none
	assign nbytes   = frame_q.remote ? 4'd0 :
		((frame_q.length_code > MAX_BYTES) ? MAX_BYTES : frame_q.length_code);
	assign data_end = 4'({1'b0, nbytes, 1'b0} - 6'd1);

	assign ident32 = {3'd0, frame_q.ident};
	assign id_nib  = frame_q.extended ? (3'd7 - cnt_q[2:0]) : (3'd2 - cnt_q[2:0]);
	assign pl_nib  = 4'd15 - cnt_q;
	assign st_nib  = 2'd3 - cnt_q[1:0];

	always_comb begin
		nib      = 4'd0;
		chr.last = 1'b0;
		seg_end  = 1'b1;
		unique case (cmd.sel)
			SEL_TYPE: begin
				if (frame_q.extended)
					chr.ascii_char = frame_q.remote ? CHAR_EXT_R : CHAR_EXT_T;
				else
					chr.ascii_char = frame_q.remote ? CHAR_STD_R : CHAR_STD_T;
			end
			SEL_IDENT: begin
				nib            = ident32[{id_nib, 2'b00} +: 4];
				chr.ascii_char = hex_char(nib);
				seg_end        = frame_q.extended ? (cnt_q == 4'd7) : (cnt_q == 4'd2);
			end
			SEL_DLC: begin
				nib            = frame_q.length_code;
				chr.ascii_char = hex_char(nib);
			end
			SEL_DATA: begin
				nib            = frame_q.payload[{pl_nib, 2'b00} +: 4];
				chr.ascii_char = hex_char(nib);
				seg_end        = (cnt_q == data_end);
			end
			SEL_STAMP: begin
				nib            = frame_q.stamp[{st_nib, 2'b00} +: 4];
				chr.ascii_char = hex_char(nib);
				seg_end        = (cnt_q == 4'd3);
			end
			SEL_CR: begin
				chr.ascii_char = CHAR_CR;
				chr.last       = 1'b1;
			end
			default: chr.ascii_char = CHAR_CR;
		endcase
	end

	assign sts.seg_end  = seg_end;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.no_data  = (nbytes == 4'd0);
	assign sts.ts_en    = ts_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_q <= chr;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_cr_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last) |-> (out_q.ascii_char != CHAR_CR))
		else $error("carriage return inside a line");
	a_last_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> (out_q.ascii_char == CHAR_CR))
		else $error("line closed without carriage return");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("output word changed before it was taken");
`endif

endmodule

// File: bench/cfa_line_checker.sv
// Checker for the CAN frame line encoder: watches both word channels and the config port,
// predicts each ASCII line from the accepted frame and compares it character by character.
// Depends on cfa_pkg for the word types and character codes.
module cfa_line_checker
	import cfa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	output int        fails,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	out_word_t line_q[$];
	logic      ts_shadow;
	int        line_no;
	int        char_no;

	function automatic logic [6:0] nibble_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return CHAR_0 + 7'(n);
		end
		return CHAR_A + 7'(n - 4'd10);
	endfunction

	function automatic void queue_char(input logic [6:0] c, input logic is_last);
		out_word_t w;
		w.ascii_char = c;
		w.last       = is_last;
		line_q.push_back(w);
	endfunction

	// builds the whole line for one frame, using the current timestamp setting
	function automatic void expand_frame(input in_word_t f);
		logic [31:0] id32;
		logic [7:0]  data_byte;
		int          k;
		int          nbytes;
		id32 = {3'b000, f.ident};
		if (f.extended) begin
			queue_char(f.remote ? CHAR_EXT_R : CHAR_EXT_T, 1'b0);
		end else begin
			queue_char(f.remote ? CHAR_STD_R : CHAR_STD_T, 1'b0);
		end
		// standard frames show only ident[11:0], whatever sits above
		for (k = (f.extended ? 7 : 2); k >= 0; k--) begin
			queue_char(nibble_char(id32[4*k +: 4]), 1'b0);
		end
		queue_char(nibble_char(f.length_code), 1'b0);
		if (f.remote) begin
			nbytes = 0;
		end else if (f.length_code > MAX_BYTES) begin
			nbytes = int'(MAX_BYTES);
		end else begin
			nbytes = int'(f.length_code);
		end
		for (k = 0; k < nbytes; k++) begin
			data_byte = f.payload[63 - 8*k -: 8];
			queue_char(nibble_char(data_byte[7:4]), 1'b0);
			queue_char(nibble_char(data_byte[3:0]), 1'b0);
		end
		if (ts_shadow) begin
			for (k = 3; k >= 0; k--) begin
				queue_char(nibble_char(f.stamp[4*k +: 4]), 1'b0);
			end
		end
		queue_char(CHAR_CR, 1'b1);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] line %0d char %0d: %s got 0x%0h want 0x%0h",
			$realtime, line_no, char_no, what, got, want);
		fails++;
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (!arst_n) begin
			ts_shadow = 1'b0;
			line_q.delete();
			line_no = 0;
			char_no = 0;
		end else begin
			if (cfg_we) begin
				ts_shadow = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (line_q.size() == 0) begin
					report_mismatch("word with no line pending", out_data, 0);
				end else begin
					want = line_q.pop_front();
					if (out_data.ascii_char !== want.ascii_char) begin
						report_mismatch("ascii_char", out_data.ascii_char, want.ascii_char);
					end
					if (out_data.last !== want.last) begin
						report_mismatch("last", out_data.last, want.last);
					end
					if (want.last) begin
						line_no++;
						char_no = 0;
					end else begin
						char_no++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expand_frame(in_data);
			end
		end
		pending = line_q.size();
	end

endmodule

// File: bench/can_frame_to_ascii_line_encoder_tb.sv
// Testbench top for can_frame_to_ascii_line_encoder: drives frames and the timestamp bit,
// throttles the output side, and prints the verdict. Checking lives in cfa_line_checker.
// Depends on cfa_pkg and cfa_line_checker.
module can_frame_to_ascii_line_encoder_tb;
	import cfa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Worst case per frame: 31 chars, each possibly stalled, plus sender gaps.
	// About 130 frames in all; the limit leaves a wide margin.
	localparam int CYCLE_LIMIT = 400000;
	// long output hold-off, so the encoder backs up and drops in_ready
	localparam int HOLD_CYCLES = 300;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;
	logic      cfg_we;
	logic      cfg_wdata;

	int        mismatch_count;
	int        chars_pending;
	int        frames_sent;
	int        cycle_count;
	bit        tx_gaps_on;
	bit        rx_stalls_on;
	bit        hold_req;

	always #1 clk = ~clk;

	can_frame_to_ascii_line_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	cfa_line_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fails     (mismatch_count),
		.pending   (chars_pending)
	);

	// Watchdog: a stuck handshake or a line that never finishes ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Output side. All changes at the falling edge. A hold request wins over
	// random stalls and keeps out_ready low in one unbroken piece.
	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req  = 1'b0;
				out_ready = 1'b1;
			end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	function automatic in_word_t make_frame(input logic [28:0] ident, input logic ext,
			input logic rtr, input logic [3:0] dlc, input logic [63:0] data,
			input logic [15:0] stamp);
		in_word_t f;
		f.ident       = ident;
		f.extended    = ext;
		f.remote      = rtr;
		f.length_code = dlc;
		f.payload     = data;
		f.stamp       = stamp;
		return f;
	endfunction

	// Random frame: mostly data frames with legal lengths, some remote frames,
	// some length codes above 8 to hit the byte clamp.
	function automatic in_word_t random_frame();
		in_word_t    f;
		logic [31:0] r_id;
		logic [31:0] r_hi;
		logic [31:0] r_lo;
		logic [31:0] r_ts;
		r_id = $urandom;
		r_hi = $urandom;
		r_lo = $urandom;
		r_ts = $urandom;
		f.ident    = r_id[28:0];
		f.extended = 1'($urandom_range(0, 1));
		f.remote   = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) < 8) begin
			f.length_code = 4'($urandom_range(0, 8));
		end else begin
			f.length_code = 4'($urandom_range(9, 15));
		end
		f.payload = {r_hi, r_lo};
		f.stamp   = r_ts[15:0];
		return f;
	endfunction

	// Offer one word and hold it until taken. Returns at the next falling edge
	// with in_valid still high, so back-to-back words never drop valid.
	task automatic send_frame(input in_word_t f);
		in_data  = f;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		frames_sent++;
		@(negedge clk);
	endtask

	// Sender goes quiet until every predicted character has come out.
	task automatic drain_lines();
		in_valid = 1'b0;
		wait (chars_pending == 0);
		@(negedge clk);
	endtask

	// Register write only with the encoder idle.
	task automatic write_timestamp_enable(input logic v);
		drain_lines();
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic send_random_frames(input int n);
		for (int i = 0; i < n; i++) begin
			if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			send_frame(random_frame());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		hold_req     = 1'b0;
		frames_sent  = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed, timestamp off (reset value) ---
		// shortest line, all-zero fields
		send_frame(make_frame(29'h0, 1'b0, 1'b0, 4'h0, 64'h0, 16'h0));
		// top standard ident, full data, all ones
		send_frame(make_frame(29'h7FF, 1'b0, 1'b0, 4'h8, '1, 16'hFFFF));
		// top extended ident, every hex digit in the data
		send_frame(make_frame(29'h1FFFFFFF, 1'b1, 1'b0, 4'h8,
			64'h0123_4567_89AB_CDEF, 16'h1234));
		send_frame(make_frame(29'h0, 1'b1, 1'b0, 4'h1, 64'hA500_0000_0000_0000, 16'h0));
		// remote frames: length digit shown, no data digits
		send_frame(make_frame(29'h123, 1'b0, 1'b1, 4'h4, '1, 16'h0));
		send_frame(make_frame(29'h1ABCDEF0, 1'b1, 1'b1, 4'hF, '1, 16'h0));
		send_frame(make_frame(29'h0, 1'b0, 1'b1, 4'h0, 64'h0, 16'h0));
		// standard frame with bits set above 11: only the low 12 show
		send_frame(make_frame(29'h1FFFF456, 1'b0, 1'b0, 4'h2,
			64'hFEDC_BA98_7654_3210, 16'h0));
		// length codes above 8: clamp to 8 bytes
		send_frame(make_frame(29'h0AB, 1'b0, 1'b0, 4'h9, 64'h89AB_CDEF_0123_4567, 16'h0));
		send_frame(make_frame(29'h10000000, 1'b1, 1'b0, 4'hF, '1, 16'h0));

		// --- directed, timestamp on ---
		write_timestamp_enable(1'b1);
		// longest line: 31 chars
		send_frame(make_frame(29'h1FFFFFFF, 1'b1, 1'b0, 4'h8, '1, 16'hFFFF));
		send_frame(make_frame(29'h0, 1'b0, 1'b0, 4'h0, 64'h0, 16'h0000));
		send_frame(make_frame(29'h555, 1'b0, 1'b1, 4'h8, 64'h0, 16'hA5C3));
		send_frame(make_frame(29'h0AAAAAAA, 1'b1, 1'b1, 4'h0, 64'h0, 16'h5A3C));
		send_frame(make_frame(29'h2AA, 1'b0, 1'b0, 4'hC, 64'h5555_AAAA_5555_AAAA, 16'h8001));
		write_timestamp_enable(1'b0);
		send_frame(make_frame(29'h15555555, 1'b1, 1'b0, 4'h3,
			64'hC3C3_C3C3_0000_0000, 16'hFFFF));

		// --- random, idling on both sides, timestamp on ---
		write_timestamp_enable(1'b1);
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		send_random_frames(30);

		// --- backpressure: long output hold while frames keep coming ---
		tx_gaps_on = 1'b0;
		hold_req   = 1'b1;
		send_random_frames(20);
		// sender waits for every line to finish before going on
		drain_lines();

		// --- random, idling on, timestamp off ---
		write_timestamp_enable(1'b0);
		tx_gaps_on = 1'b1;
		send_random_frames(30);

		// --- last stretch: timestamp on, no idling anywhere ---
		write_timestamp_enable(1'b1);
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		send_random_frames(34);

		in_valid = 1'b0;
		wait (chars_pending == 0);
		// catch any stray word after the last line
		repeat (40) @(posedge clk);

		$display("Covered %0d frames: standard/extended, data/remote, length codes 0-15,",
			frames_sent);
		$display("timestamp off and on, random stalls and a long output hold-off.");
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
